>>> design/weighted_category_nearest_match_top_macros.svh
// Assertion macros shared by the nearest match checker.
`ifndef WEIGHTED_CATEGORY_NEAREST_MATCH_TOP_MACROS_SVH
`define WEIGHTED_CATEGORY_NEAREST_MATCH_TOP_MACROS_SVH

// check cons in the same cycle as ante
`define WCNM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nearest match check failed");

// check cons in the cycle after ante
`define WCNM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nearest match check failed");

`endif

>>> design/wcnm_pkg.sv
// Shared constants, controller states and control structs for the nearest match block.
package wcnm_pkg;

    localparam int WCNM_MAX_ENTRIES = 256;
    localparam int WCNM_INDEX_BITS  = 9;

    localparam int NUM_CATS    = 4;
    localparam int CAT_BITS    = 2;
    localparam int SLOT_BITS   = 8;
    localparam int COUNT_BITS  = 9;
    localparam int NUMBER_BITS = 9;
    localparam int DIST_BITS   = 40;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WISH,
        ST_SCAN,
        ST_DRAIN,
        ST_RESULT
    } wcnm_state_t;

    typedef struct packed {
        logic take;
        logic rd_wish;
        logic weight_sq;
        logic load_wish;
        logic scan_issue;
        logic load_result;
    } wcnm_cmd_t;

    typedef struct packed {
        logic bad;
        logic scan_last;
        logic pipe_busy;
        logic out_free;
    } wcnm_status_t;

endpackage

>>> design/wcnm_ram.sv
// Generic single write, single read RAM with registered read data.
module wcnm_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> design/wcnm_ctrl.sv
// Controller state machine sequencing writes, query setup, scan, drain and result.
module wcnm_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    mode,
    input  wcnm_pkg::wcnm_status_t  status,
    output wcnm_pkg::wcnm_cmd_t     cmd,
    output logic                    in_stall
);

    import wcnm_pkg::*;

    wcnm_state_t state_reg;
    wcnm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (mode == MODE_QUERY))
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = status.bad ? ST_RESULT : ST_WISH;
            end
            ST_WISH:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.take = 1'b1;
                in_stall = 1'b0;
            end
            ST_CHECK:
            begin
                cmd.rd_wish   = 1'b1;
                cmd.weight_sq = 1'b1;
            end
            ST_WISH:
            begin
                cmd.load_wish = 1'b1;
            end
            ST_SCAN:
            begin
                cmd.scan_issue = 1'b1;
            end
            ST_DRAIN:
            begin
                cmd = '0;
            end
            ST_RESULT:
            begin
                cmd.load_result = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> design/wcnm_dp.sv
// Datapath: count register, index table, weights, scan pipeline, best tracking, result register.
module wcnm_dp #(
    parameter int MAX_ENTRIES = wcnm_pkg::WCNM_MAX_ENTRIES,
    parameter int INDEX_BITS  = wcnm_pkg::WCNM_INDEX_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  wcnm_pkg::wcnm_cmd_t                  cmd,
    output wcnm_pkg::wcnm_status_t               status,
    input  logic                                 in_valid,
    input  logic                                 mode,
    input  logic [wcnm_pkg::SLOT_BITS-1:0]       slot,
    input  logic signed [INDEX_BITS-1:0]         first_index,
    input  logic signed [INDEX_BITS-1:0]         second_index,
    input  logic signed [INDEX_BITS-1:0]         third_index,
    input  logic signed [INDEX_BITS-1:0]         fourth_index,
    input  logic [wcnm_pkg::COUNT_BITS-1:0]      current_number,
    input  logic [wcnm_pkg::CAT_BITS-1:0]        which_category,
    input  logic signed [INDEX_BITS-1:0]         wanted_index,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [wcnm_pkg::COUNT_BITS-1:0]      cfg_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [wcnm_pkg::NUMBER_BITS-1:0]     best_number,
    output logic                                 matched,
    output logic                                 bad_request
);

    import wcnm_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int NW = $clog2(MAX_ENTRIES + 1);
    localparam int WW = 3 * NW;
    localparam int PW = INDEX_BITS + WW;
    localparam int SW = PW + 2;
    localparam int TW = NUM_CATS * INDEX_BITS;
    localparam logic [63:0] DIST_MAX64 = (64'd1 << DIST_BITS) - 64'd1;

    logic [COUNT_BITS-1:0]  count_reg;
    logic [NW-1:0]          n_eff;

    logic                   xfer;
    logic [31:0]            slot_w;
    logic                   wr_en;
    logic [TW-1:0]          wr_data;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [AW-1:0]          wish_addr;
    logic [31:0]            cur_less;
    logic [TW-1:0]          rd_data;
    logic signed [INDEX_BITS-1:0] rd_entry [NUM_CATS];

    logic [COUNT_BITS-1:0]  cur_reg;
    logic [CAT_BITS-1:0]    cat_reg;
    logic signed [INDEX_BITS-1:0] wanted_reg;
    logic signed [INDEX_BITS-1:0] wish_reg [NUM_CATS];

    logic [2*NW-1:0]        w2_reg;
    logic [WW-1:0]          w3_reg;
    logic [WW-1:0]          wt [NUM_CATS];

    logic [AW-1:0]          pos_reg;
    logic                   v1_reg;
    logic                   v2_reg;
    logic                   v3_reg;
    logic [AW-1:0]          slot1_reg;
    logic [AW-1:0]          slot2_reg;
    logic [AW-1:0]          slot3_reg;
    logic                   match2_reg;
    logic                   match3_reg;
    logic [INDEX_BITS-1:0]  ad2_reg [NUM_CATS];
    logic [PW-1:0]          prod3_reg [NUM_CATS];
    logic signed [INDEX_BITS:0] diff [NUM_CATS];
    logic [INDEX_BITS:0]    mag [NUM_CATS];

    logic [SW-1:0]          sum;
    logic [63:0]            sum64;
    logic [DIST_BITS-1:0]   score;
    logic                   take_best;
    logic                   found_reg;
    logic [DIST_BITS-1:0]   best_dist_reg;
    logic [AW-1:0]          best_slot_reg;

    logic                   out_valid_reg;
    logic [NUMBER_BITS-1:0] best_number_reg;
    logic                   matched_reg;
    logic                   bad_request_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_BITS'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            count_reg <= cfg_data;
        end
    end

    assign n_eff = (32'(count_reg) > MAX_ENTRIES) ? NW'(MAX_ENTRIES) : NW'(count_reg);

    // table write
    assign xfer    = in_valid && cmd.take;
    assign slot_w  = 32'(slot);
    assign wr_en   = xfer && (mode == MODE_WRITE) && (slot_w < MAX_ENTRIES);
    assign wr_data = {fourth_index, third_index, second_index, first_index};

    assign cur_less  = 32'(cur_reg) - 32'd1;
    assign wish_addr = cur_less[AW-1:0];
    assign rd_en     = cmd.rd_wish || cmd.scan_issue;
    assign rd_addr   = cmd.scan_issue ? pos_reg : wish_addr;

    wcnm_ram #(
        .WIDTH (TW),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (slot_w[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        for (int c = 0; c < NUM_CATS; c++)
        begin
            rd_entry[c] = $signed(rd_data[c*INDEX_BITS +: INDEX_BITS]);
        end
    end

    // query fields
    always_ff @(posedge clk)
    begin
        if (xfer && (mode == MODE_QUERY))
        begin
            cur_reg    <= current_number;
            cat_reg    <= which_category;
            wanted_reg <= wanted_index;
        end
    end

    // weights N^3, N^2, N, 1
    always_ff @(posedge clk)
    begin
        if (cmd.weight_sq)
        begin
            w2_reg <= (2*NW)'(n_eff) * (2*NW)'(n_eff);
        end
        if (cmd.load_wish)
        begin
            w3_reg <= WW'(w2_reg) * WW'(n_eff);
        end
    end

    assign wt[0] = w3_reg;
    assign wt[1] = WW'(w2_reg);
    assign wt[2] = WW'(n_eff);
    assign wt[3] = WW'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.load_wish)
        begin
            for (int c = 0; c < NUM_CATS; c++)
            begin
                wish_reg[c] <= (32'(cat_reg) == c) ? wanted_reg : rd_entry[c];
            end
        end
    end

    // scan position and pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load_wish)
            begin
                pos_reg <= '0;
            end
            else if (cmd.scan_issue)
            begin
                pos_reg <= pos_reg + AW'(1);
            end
            v1_reg <= cmd.scan_issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_comb
    begin
        for (int c = 0; c < NUM_CATS; c++)
        begin
            diff[c] = $signed({wish_reg[c][INDEX_BITS-1], wish_reg[c]})
                    - $signed({rd_entry[c][INDEX_BITS-1], rd_entry[c]});
            mag[c]  = diff[c][INDEX_BITS] ? (~diff[c] + 1'b1) : diff[c];
        end
    end

    // filter and absolute differences, then weighted products
    always_ff @(posedge clk)
    begin
        slot1_reg <= pos_reg;
        if (v1_reg)
        begin
            slot2_reg  <= slot1_reg;
            match2_reg <= (rd_entry[cat_reg] == wanted_reg);
            for (int c = 0; c < NUM_CATS; c++)
            begin
                ad2_reg[c] <= mag[c][INDEX_BITS-1:0];
            end
        end
        if (v2_reg)
        begin
            slot3_reg  <= slot2_reg;
            match3_reg <= match2_reg;
            for (int c = 0; c < NUM_CATS; c++)
            begin
                prod3_reg[c] <= PW'(ad2_reg[c]) * PW'(wt[c]);
            end
        end
    end

    assign sum = SW'(prod3_reg[0]) + SW'(prod3_reg[1]) + SW'(prod3_reg[2])
               + SW'(prod3_reg[3]);
    assign sum64 = 64'(sum);
    assign score = (sum64 > DIST_MAX64) ? DIST_MAX64[DIST_BITS-1:0] : sum64[DIST_BITS-1:0];
    assign take_best = v3_reg && match3_reg && (!found_reg || (score < best_dist_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (cmd.load_wish)
        begin
            found_reg <= 1'b0;
        end
        else if (take_best)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_wish)
        begin
            best_dist_reg <= '1;
            best_slot_reg <= '0;
        end
        else if (take_best)
        begin
            best_dist_reg <= score;
            best_slot_reg <= slot3_reg;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            if (status.bad)
            begin
                best_number_reg <= NUMBER_BITS'(1);
                matched_reg     <= 1'b0;
                bad_request_reg <= 1'b1;
            end
            else
            begin
                best_number_reg <= found_reg ? NUMBER_BITS'(32'(best_slot_reg) + 32'd1)
                                             : NUMBER_BITS'(1);
                matched_reg     <= found_reg;
                bad_request_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign best_number = best_number_reg;
    assign matched     = matched_reg;
    assign bad_request = bad_request_reg;

    assign status.bad       = (cur_reg == '0) || (32'(cur_reg) > 32'(n_eff));
    assign status.scan_last = (32'(pos_reg) == (32'(n_eff) - 32'd1));
    assign status.pipe_busy = v1_reg || v2_reg || v3_reg;
    assign status.out_free  = !out_valid_reg || !out_stall;

endmodule

>>> design/weighted_category_nearest_match_top.sv
// Top level of the weighted category nearest match block.
//
//  channel   direction  handshake            payload
//  in        to block   in_valid / in_stall  mode, slot, four indices, query fields
//  out       from block out_valid / out_stall best_number, matched, bad_request
//  cfg       to block   cfg_valid / cfg_ready cfg_data (entry count)
//
// A write transfer leaves the controller idle, so the block is ready again in the next cycle.
// A query scans the N table entries, N the entry count, with one table read per cycle
// through the single read port during the scan; a bad request skips the scan.
// No clearing pass after reset: table entries are undefined until written.
// A finished result waits in the output register while out_stall is high.
module weighted_category_nearest_match_top #(
    parameter int MAX_ENTRIES = wcnm_pkg::WCNM_MAX_ENTRIES,
    parameter int INDEX_BITS  = wcnm_pkg::WCNM_INDEX_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             mode,
    input  logic [wcnm_pkg::SLOT_BITS-1:0]   slot,
    input  logic signed [INDEX_BITS-1:0]     first_index,
    input  logic signed [INDEX_BITS-1:0]     second_index,
    input  logic signed [INDEX_BITS-1:0]     third_index,
    input  logic signed [INDEX_BITS-1:0]     fourth_index,
    input  logic [wcnm_pkg::COUNT_BITS-1:0]  current_number,
    input  logic [wcnm_pkg::CAT_BITS-1:0]    which_category,
    input  logic signed [INDEX_BITS-1:0]     wanted_index,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [wcnm_pkg::COUNT_BITS-1:0]  cfg_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [wcnm_pkg::NUMBER_BITS-1:0] best_number,
    output logic                             matched,
    output logic                             bad_request
);

    import wcnm_pkg::*;

    wcnm_cmd_t    cmd;
    wcnm_status_t status;

    wcnm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .mode     (mode),
        .status   (status),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    wcnm_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .INDEX_BITS  (INDEX_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .in_valid       (in_valid),
        .mode           (mode),
        .slot           (slot),
        .first_index    (first_index),
        .second_index   (second_index),
        .third_index    (third_index),
        .fourth_index   (fourth_index),
        .current_number (current_number),
        .which_category (which_category),
        .wanted_index   (wanted_index),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .best_number    (best_number),
        .matched        (matched),
        .bad_request    (bad_request)
    );

endmodule

>>> design/wcnm_checker.sv
// Port-level checker for the nearest match block, bound to the top level.
`include "weighted_category_nearest_match_top_macros.svh"

module wcnm_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic                             mode,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic [wcnm_pkg::NUMBER_BITS-1:0] best_number,
    input logic                             matched,
    input logic                             bad_request
);

    import wcnm_pkg::*;

    `WCNM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    `WCNM_ASSERT_NOW(a_bad_fields, out_valid && bad_request, !matched && (best_number == NUMBER_BITS'(1)))
    `WCNM_ASSERT_NOW(a_nomatch_one, out_valid && !matched, best_number == NUMBER_BITS'(1))
    `WCNM_ASSERT_NEXT(a_query_busy, in_valid && !in_stall && (mode == MODE_QUERY), in_stall)

endmodule

bind weighted_category_nearest_match_top wcnm_checker u_checker (.*);

>>> test/tb_weighted_category_nearest_match_top.sv
// Self-checking testbench for the weighted category nearest match block.
module tb_weighted_category_nearest_match_top;

    localparam int ENTRY_SLOTS = wcnm_pkg::WCNM_MAX_ENTRIES;
    localparam longint unsigned DIST_LIMIT = (64'd1 << wcnm_pkg::DIST_BITS) - 64'd1;

    typedef struct {
        logic                                   mode;
        logic [wcnm_pkg::SLOT_BITS-1:0]         slot;
        logic signed [wcnm_pkg::WCNM_INDEX_BITS-1:0] first_index;
        logic signed [wcnm_pkg::WCNM_INDEX_BITS-1:0] second_index;
        logic signed [wcnm_pkg::WCNM_INDEX_BITS-1:0] third_index;
        logic signed [wcnm_pkg::WCNM_INDEX_BITS-1:0] fourth_index;
        logic [wcnm_pkg::COUNT_BITS-1:0]        current_number;
        logic [wcnm_pkg::CAT_BITS-1:0]          which_category;
        logic signed [wcnm_pkg::WCNM_INDEX_BITS-1:0] wanted_index;
    } request_t;

    typedef struct {
        logic [wcnm_pkg::NUMBER_BITS-1:0] best_number;
        logic                             matched;
        logic                             bad_request;
    } answer_t;

    class nearest_match_scoreboard;
        int          entries [ENTRY_SLOTS][wcnm_pkg::NUM_CATS];
        int unsigned entry_count;
        answer_t     pending_answers [$];
        int          errors;

        function new();
            entry_count = 1;
            errors = 0;
            foreach (entries[s, c])
                entries[s][c] = 0;
        endfunction

        function int active_entries();
            return (entry_count > ENTRY_SLOTS) ? ENTRY_SLOTS : int'(entry_count);
        endfunction

        function void set_count(logic [wcnm_pkg::COUNT_BITS-1:0] value);
            entry_count = value;
        endfunction

        function int pending_count();
            return pending_answers.size();
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function answer_t predict_match(request_t req);
            answer_t         ans;
            int              n;
            int              cur;
            int              cat;
            int              wanted;
            int              d;
            int              best_slot;
            int              wish [wcnm_pkg::NUM_CATS];
            longint unsigned weight [wcnm_pkg::NUM_CATS];
            longint unsigned score;
            longint unsigned best_dist;
            bit              found;
            n = active_entries();
            cur = req.current_number;
            cat = req.which_category;
            wanted = $signed(req.wanted_index);
            ans.best_number = 1;
            ans.matched = 1'b0;
            ans.bad_request = 1'b0;
            if (cur == 0 || cur > n)
            begin
                ans.bad_request = 1'b1;
                return ans;
            end
            weight[3] = 1;
            weight[2] = n;
            weight[1] = longint'(n) * n;
            weight[0] = longint'(n) * n * n;
            for (int c = 0; c < wcnm_pkg::NUM_CATS; c++)
                wish[c] = entries[cur-1][c];
            wish[cat] = wanted;
            found = 1'b0;
            best_dist = DIST_LIMIT;
            best_slot = 0;
            for (int p = 0; p < n; p++)
            begin
                if (entries[p][cat] == wanted)
                begin
                    score = 0;
                    for (int c = 0; c < wcnm_pkg::NUM_CATS; c++)
                    begin
                        d = wish[c] - entries[p][c];
                        if (d < 0)
                            d = -d;
                        score = score + longint'(d) * weight[c];
                        if (score > DIST_LIMIT)
                            score = DIST_LIMIT;
                    end
                    if (!found || score < best_dist)
                    begin
                        best_dist = score;
                        best_slot = p;
                        found = 1'b1;
                    end
                end
            end
            if (found)
            begin
                ans.best_number = 9'(best_slot + 1);
                ans.matched = 1'b1;
            end
            return ans;
        endfunction

        function void note_request(request_t req);
            if (req.mode == wcnm_pkg::MODE_WRITE)
            begin
                entries[req.slot][0] = $signed(req.first_index);
                entries[req.slot][1] = $signed(req.second_index);
                entries[req.slot][2] = $signed(req.third_index);
                entries[req.slot][3] = $signed(req.fourth_index);
            end
            else
                pending_answers.insert(pending_answers.size(), predict_match(req));
        endfunction

        task check_answer(answer_t got);
            answer_t want;
            if (pending_answers.size() == 0)
            begin
                report_mismatch($sformatf("result with no query outstanding, best_number %0d",
                                          got.best_number));
                return;
            end
            want = pending_answers.pop_front();
            if (got.best_number !== want.best_number)
                report_mismatch($sformatf("best_number %0d, expected %0d",
                                          got.best_number, want.best_number));
            if (got.matched !== want.matched)
                report_mismatch($sformatf("matched %0b, expected %0b",
                                          got.matched, want.matched));
            if (got.bad_request !== want.bad_request)
                report_mismatch($sformatf("bad_request %0b, expected %0b",
                                          got.bad_request, want.bad_request));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic mode = 1'b0;
    logic [wcnm_pkg::SLOT_BITS-1:0] slot = '0;
    logic signed [wcnm_pkg::WCNM_INDEX_BITS-1:0] first_index = '0;
    logic signed [wcnm_pkg::WCNM_INDEX_BITS-1:0] second_index = '0;
    logic signed [wcnm_pkg::WCNM_INDEX_BITS-1:0] third_index = '0;
    logic signed [wcnm_pkg::WCNM_INDEX_BITS-1:0] fourth_index = '0;
    logic [wcnm_pkg::COUNT_BITS-1:0] current_number = '0;
    logic [wcnm_pkg::CAT_BITS-1:0] which_category = '0;
    logic signed [wcnm_pkg::WCNM_INDEX_BITS-1:0] wanted_index = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [wcnm_pkg::COUNT_BITS-1:0] cfg_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [wcnm_pkg::NUMBER_BITS-1:0] best_number;
    logic matched;
    logic bad_request;

    nearest_match_scoreboard sb;
    int send_idle_pct = 20;
    int recv_idle_pct = 82;
    int value_pool = 4;
    int random_items = 0;

    weighted_category_nearest_match_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .slot           (slot),
        .first_index    (first_index),
        .second_index   (second_index),
        .third_index    (third_index),
        .fourth_index   (fourth_index),
        .current_number (current_number),
        .which_category (which_category),
        .wanted_index   (wanted_index),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .best_number    (best_number),
        .matched        (matched),
        .bad_request    (bad_request)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin : answer_monitor
        answer_t seen;
        if (out_valid && !out_stall)
        begin
            seen.best_number = best_number;
            seen.matched = matched;
            seen.bad_request = bad_request;
            sb.check_answer(seen);
        end
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    function automatic logic signed [8:0] pick_index();
        int v;
        if ($urandom_range(9) == 0)
            v = int'($urandom_range(256)) - 1;
        else
            v = int'($urandom_range(value_pool)) - 1;
        return v[8:0];
    endfunction

    function automatic request_t write_request(int s, int a, int b, int c, int d);
        request_t req;
        req.mode = wcnm_pkg::MODE_WRITE;
        req.slot = 8'(s);
        req.first_index = 9'(a);
        req.second_index = 9'(b);
        req.third_index = 9'(c);
        req.fourth_index = 9'(d);
        req.current_number = '0;
        req.which_category = '0;
        req.wanted_index = '0;
        return req;
    endfunction

    function automatic request_t query_request(int cur, int cat, int wanted);
        request_t req;
        req = write_request(0, 0, 0, 0, 0);
        req.mode = wcnm_pkg::MODE_QUERY;
        req.current_number = 9'(cur);
        req.which_category = 2'(cat);
        req.wanted_index = 9'(wanted);
        return req;
    endfunction

    function automatic request_t random_request();
        request_t req;
        int n;
        n = sb.active_entries();
        req.mode = ($urandom_range(99) < 40) ? wcnm_pkg::MODE_WRITE : wcnm_pkg::MODE_QUERY;
        req.slot = 8'($urandom_range(255));
        if (req.mode == wcnm_pkg::MODE_WRITE && n > 0 && $urandom_range(99) < 85)
            req.slot = 8'($urandom_range(n - 1));
        req.first_index = pick_index();
        req.second_index = pick_index();
        req.third_index = pick_index();
        req.fourth_index = pick_index();
        req.current_number = 9'($urandom_range(511));
        if (n > 0 && $urandom_range(99) < 85)
            req.current_number = 9'($urandom_range(n, 1));
        req.which_category = 2'($urandom_range(3));
        req.wanted_index = pick_index();
        if (n > 0 && $urandom_range(1) == 0)
            req.wanted_index = 9'(sb.entries[$urandom_range(n - 1)][req.which_category]);
        return req;
    endfunction

    task automatic send_request(request_t req);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= req.mode;
        slot <= req.slot;
        first_index <= req.first_index;
        second_index <= req.second_index;
        third_index <= req.third_index;
        fourth_index <= req.fourth_index;
        current_number <= req.current_number;
        which_category <= req.which_category;
        wanted_index <= req.wanted_index;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_request(req);
    endtask

    // hold off until every query has answered and a trailing write has landed
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending_count() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic load_entry_count(int value);
        cfg_valid <= 1'b1;
        cfg_data <= 9'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_count(9'(value));
    endtask

    task automatic update_pace();
        if (random_items < 330)
        begin
            send_idle_pct = 20;
            recv_idle_pct = 82;
        end
        else if (random_items < 660)
        begin
            send_idle_pct = 82;
            recv_idle_pct = 20;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    initial
    begin
        #12000000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin : stimulus
        int r;
        int phase_len;
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int s = 0; s < ENTRY_SLOTS; s++)
            send_request(write_request(s, pick_index(), pick_index(), pick_index(),
                                       pick_index()));

        send_request(write_request(0, 5, -1, 255, 0));
        send_request(query_request(1, 0, 5));
        send_request(query_request(1, 1, 7));
        send_request(query_request(0, 2, 0));
        send_request(query_request(2, 3, 0));
        send_request(query_request(511, 0, -1));
        settle();

        load_entry_count(4);
        send_request(write_request(0, -1, -1, -1, -1));
        send_request(write_request(1, 255, 255, 255, 255));
        send_request(write_request(2, 0, 0, 0, 0));
        send_request(write_request(3, 0, 0, 0, 0));
        send_request(query_request(1, 0, 0));
        send_request(query_request(2, 3, -1));
        send_request(query_request(3, 2, 255));
        send_request(query_request(4, 1, 0));
        send_request(query_request(4, 0, 1));
        send_request(query_request(5, 1, 0));
        settle();

        load_entry_count(0);
        send_request(query_request(1, 0, 0));
        settle();

        load_entry_count(511);
        send_request(query_request(256, 2, sb.entries[200][2]));
        settle();

        load_entry_count(256);
        send_request(query_request(1, 3, sb.entries[255][3]));
        settle();

        while (random_items < 1000)
        begin
            r = $urandom_range(99);
            if (r < 60)
                load_entry_count($urandom_range(16, 1));
            else if (r < 75)
                load_entry_count($urandom_range(255, 17));
            else if (r < 83)
                load_entry_count(256);
            else if (r < 88)
                load_entry_count($urandom_range(511, 257));
            else if (r < 93)
                load_entry_count(0);
            else
                load_entry_count($urandom_range(4, 2));
            value_pool = $urandom_range(6, 2);
            phase_len = $urandom_range(60, 30);
            for (int i = 0; i < phase_len; i++)
            begin
                update_pace();
                send_request(random_request());
                random_items++;
                if ($urandom_range(99) == 0)
                    settle();
            end
            settle();
        end

        repeat (270) @(posedge clk);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
